[src/assert_macros.svh]
// assertion helpers for the codec
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define B64_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("codec assertion failed");
`define B64_NEVER(lbl, clk, rst, cond) \
  `B64_ASSERT(lbl, clk, rst, !(cond))
`else
`define B64_ASSERT(lbl, clk, rst, prop)
`define B64_NEVER(lbl, clk, rst, cond)
`endif

`endif

[src/b64sc_pkg.sv]
package b64sc_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [23:0] bits;
    logic [2:0]  cnt;
    logic [1:0]  pads;
    logic        last;
    logic        dec;
  } job_t;

  function automatic logic [7:0] enc_char(input logic [5:0] s);
    logic [7:0] s8;
    s8 = {2'b00, s};
    if (s < 6'd26) begin
      return 8'h41 + s8;
    end else if (s < 6'd52) begin
      return 8'h61 + s8 - 8'd26;
    end else if (s < 6'd62) begin
      return 8'h30 + s8 - 8'd52;
    end else if (s == 6'd62) begin
      return 8'h2B;
    end
    return 8'h2F;
  endfunction

  function automatic logic [5:0] dec_sextet(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'h00;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      v = ch - 8'h41;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      v = ch - 8'h61 + 8'd26;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      v = ch - 8'h30 + 8'd52;
    end else if (ch == 8'h2B) begin
      v = 8'd62;
    end else if (ch == 8'h2F) begin
      v = 8'd63;
    end
    return v[5:0];
  endfunction

endpackage

[src/b64sc_in_if.sv]
interface b64sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

[src/b64sc_out_if.sv]
interface b64sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

[src/b64sc_cfg_if.sv]
interface b64sc_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, output mode, input ready);
  modport sink (input valid, input mode, output ready);
endinterface

[src/b64sc_front.sv]
module b64sc_front (
  input  logic             clk,
  input  logic             rst,
  b64sc_in_if.sink         feed,
  b64sc_cfg_if.sink        cfg,
  input  logic             q_full,
  output logic             q_push,
  output b64sc_pkg::job_t  job
);
  import b64sc_pkg::*;

  logic        mode;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [1:0]  pad_flags, pad_flags_next;

  logic        accept;
  logic [1:0]  eff_fill;
  logic [2:0]  fill_inc;
  logic [23:0] enc_ins, dec_ins, bits_new;
  logic [5:0]  sx;
  logic        is_pad;
  logic [1:0]  pf_new;
  logic [2:0]  pad_cnt;

  assign feed.ready = !q_full;
  assign cfg.ready  = 1'b1;
  assign accept     = feed.valid && feed.ready;

  assign eff_fill = (group_fill == 2'd3) ? 2'd2 : group_fill;
  assign fill_inc = {1'b0, eff_fill} + 3'd1;
  assign sx       = dec_sextet(feed.in_byte);
  assign is_pad   = (feed.in_byte == PAD_CHAR);

  always_comb begin
    case (eff_fill)
      2'd0:    enc_ins = {feed.in_byte, 16'h0000};
      2'd1:    enc_ins = {8'h00, feed.in_byte, 8'h00};
      default: enc_ins = {16'h0000, feed.in_byte};
    endcase
    case (group_fill)
      2'd0:    dec_ins = {sx, 18'h00000};
      2'd1:    dec_ins = {6'h00, sx, 12'h000};
      2'd2:    dec_ins = {12'h000, sx, 6'h00};
      default: dec_ins = {18'h00000, sx};
    endcase
  end

  always_comb begin
    group_bits_next = group_bits;
    group_fill_next = group_fill;
    pad_flags_next  = pad_flags;
    q_push          = 1'b0;
    job             = '0;
    bits_new        = group_bits;
    pf_new          = pad_flags;
    pad_cnt         = 3'd0;
    if (accept) begin
      if (mode == MODE_ENCODE) begin
        bits_new = group_bits | enc_ins;
        if (fill_inc < 3'd3 && !feed.in_last) begin
          group_bits_next = bits_new;
          group_fill_next = fill_inc[1:0];
        end else begin
          q_push          = 1'b1;
          job.bits        = bits_new;
          job.cnt         = 3'd4;
          job.pads        = 2'(3'd3 - fill_inc);
          job.last        = feed.in_last;
          job.dec         = 1'b0;
          group_bits_next = '0;
          group_fill_next = '0;
          pad_flags_next  = '0;
        end
      end else begin
        bits_new = group_bits | dec_ins;
        if (group_fill == 2'd2 && is_pad) begin
          pf_new[0] = 1'b1;
        end
        if (group_fill != 2'd3) begin
          if (feed.in_last) begin
            group_bits_next = '0;
            group_fill_next = '0;
            pad_flags_next  = '0;
          end else begin
            group_bits_next = bits_new;
            group_fill_next = group_fill + 2'd1;
            pad_flags_next  = pf_new;
          end
        end else begin
          if (is_pad) begin
            pf_new[1] = 1'b1;
          end
          if (feed.in_last) begin
            pad_cnt = {2'b00, pf_new[0]} + {2'b00, pf_new[1]};
          end
          q_push          = 1'b1;
          job.bits        = bits_new;
          job.cnt         = 3'd3 - pad_cnt;
          job.pads        = 2'd0;
          job.last        = feed.in_last;
          job.dec         = 1'b1;
          group_bits_next = '0;
          group_fill_next = '0;
          pad_flags_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ENCODE;
      group_bits <= '0;
      group_fill <= '0;
      pad_flags  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      mode       <= cfg.mode;
      group_bits <= '0;
      group_fill <= '0;
      pad_flags  <= '0;
    end else begin
      group_bits <= group_bits_next;
      group_fill <= group_fill_next;
      pad_flags  <= pad_flags_next;
    end
  end

endmodule

[src/b64sc_queue.sv]
module b64sc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  b64sc_pkg::job_t  wr_job,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output b64sc_pkg::job_t  rd_job
);
  import b64sc_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[src/b64sc_back.sv]
module b64sc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  b64sc_pkg::job_t  q_job,
  output logic             q_pop,
  b64sc_out_if.source      drain
);
  import b64sc_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_last;

  logic       advance;
  logic       final_beat;
  logic [5:0] sextet;
  logic [7:0] data_byte;
  logic [7:0] item;

  assign drain.valid    = o_valid;
  assign drain.out_byte = o_byte;
  assign drain.out_last = o_last;

  assign advance    = cur_valid && (!o_valid || drain.ready);
  assign final_beat = ({1'b0, idx} == (cur.cnt - 3'd1));
  assign q_pop      = q_valid && (!cur_valid || (advance && final_beat));

  always_comb begin
    case (idx)
      2'd0:    sextet = cur.bits[23:18];
      2'd1:    sextet = cur.bits[17:12];
      2'd2:    sextet = cur.bits[11:6];
      default: sextet = cur.bits[5:0];
    endcase
    case (idx)
      2'd0:    data_byte = cur.bits[23:16];
      2'd1:    data_byte = cur.bits[15:8];
      default: data_byte = cur.bits[7:0];
    endcase
    if (cur.dec) begin
      item = data_byte;
    end else if ({1'b0, idx} >= (3'd4 - {1'b0, cur.pads})) begin
      item = PAD_CHAR;
    end else begin
      item = enc_char(sextet);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_byte <= item;
      o_last <= cur.last && final_beat;
    end
    if (q_pop) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      o_valid   <= 1'b0;
    end else begin
      if (advance) begin
        o_valid <= 1'b1;
      end else if (drain.ready) begin
        o_valid <= 1'b0;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (advance) begin
        if (final_beat) begin
          cur_valid <= 1'b0;
          idx       <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

endmodule

[src/base64_stream_codec_unit.sv]
// a completed group passes through the job queue, the current-job register and the output register
// encode throughput: 4 output beats per 3 input bytes, one output beat a cycle while the drain is ready
// decode throughput: one input beat a cycle while the queue has room, up to 3 output beats per 4 inputs
// rate set by the single output register draining one beat per cycle while the drain is ready
// reset: synchronous, clears mode to encode, the partial group, queue and output
`include "assert_macros.svh"

module base64_stream_codec_unit (
  input  logic        clk,
  input  logic        rst,
  b64sc_in_if.sink    feed,
  b64sc_cfg_if.sink   cfg,
  b64sc_out_if.source drain
);
  import b64sc_pkg::*;

  logic q_push, q_full, q_pop, q_valid;
  job_t job, q_job;

  b64sc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .job    (job)
  );

  b64sc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_job   (job),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_job   (q_job)
  );

  b64sc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_job),
    .q_pop   (q_pop),
    .drain   (drain)
  );

  `B64_NEVER(a_queue_overflow, clk, rst, q_push && q_full)
  `B64_NEVER(a_queue_underflow, clk, rst, q_pop && !q_valid)
  `B64_ASSERT(a_job_count, clk, rst, q_push |-> (job.cnt != 3'd0 && job.cnt <= 3'd4))
  `B64_ASSERT(a_encode_four, clk, rst, (q_push && !job.dec) |-> (job.cnt == 3'd4))

endmodule

[verif/base64_stream_codec_unit_test.sv]
`timescale 1ns / 1ps

module base64_stream_codec_unit_test;
  import b64sc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  localparam int SEND_IDLE[4]  = '{0, 81, 0, 17};
  localparam int RECV_STALL[4] = '{0, 0, 81, 17};

  logic clk = 1'b0;
  logic rst;

  b64sc_in_if  feed_if ();
  b64sc_cfg_if cfg_if ();
  b64sc_out_if drain_if ();

  base64_stream_codec_unit dut (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed_if),
    .cfg   (cfg_if),
    .drain (drain_if)
  );

  beat_t feed_q[$];
  beat_t drain_q[$];

  // codec state as the block should hold it
  logic        cur_mode;
  logic [23:0] grp_bits;
  logic [1:0]  grp_fill;
  logic [1:0]  pad_seen;

  int idle_pct = 0;
  int stall_pct = 0;
  int items_fed = 0;
  int beats_checked = 0;
  int mode_writes = 0;
  int mismatches = 0;

  always #5 clk = ~clk;

  function automatic logic [7:0] sextet_char(input logic [5:0] s);
    return ALPHABET[8 * (63 - s) +: 8];
  endfunction

  function automatic logic [5:0] char_sextet(input logic [7:0] ch);
    for (int s = 0; s < 64; s++) begin
      if (sextet_char(6'(s)) == ch) begin
        return 6'(s);
      end
    end
    return 6'd0;
  endfunction

  function automatic void forget_group();
    grp_bits = '0;
    grp_fill = '0;
    pad_seen = '0;
  endfunction

  function automatic void codec_step(input beat_t b);
    int fill;
    int n;
    logic [7:0] ch;
    fill = int'(grp_fill);
    if (cur_mode == MODE_ENCODE) begin
      if (fill > 2) begin
        fill = 2;
      end
      grp_bits = grp_bits | (24'(b.data) << (16 - 8 * fill));
      fill++;
      if (fill < 3 && !b.last) begin
        grp_fill = 2'(fill);
        return;
      end
      for (int k = 0; k < 4; k++) begin
        ch = sextet_char(grp_bits[23 - 6 * k -: 6]);
        // unused trailing characters of a short final group
        if (k >= fill + 1) begin
          ch = PAD_CHAR;
        end
        drain_q.push_back('{data: ch, last: b.last && k == 3});
      end
    end else begin
      grp_bits = grp_bits | (24'(char_sextet(b.data)) << (18 - 6 * fill));
      if (fill == 2 && b.data == PAD_CHAR) begin
        pad_seen[0] = 1'b1;
      end
      if (fill < 3) begin
        if (b.last) begin
          forget_group();
        end else begin
          grp_fill = 2'(fill + 1);
        end
        return;
      end
      if (b.data == PAD_CHAR) begin
        pad_seen[1] = 1'b1;
      end
      n = 3;
      if (b.last) begin
        n = n - int'(pad_seen[0]) - int'(pad_seen[1]);
      end
      for (int k = 0; k < n; k++) begin
        drain_q.push_back('{data: grp_bits[23 - 8 * k -: 8], last: b.last && k == n - 1});
      end
    end
    forget_group();
  endfunction

  function automatic void note_failure(input string what);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch: %s", what);
    end
  endfunction

  // feed driver
  always @(posedge clk) begin
    if (rst) begin
      feed_if.valid <= 1'b0;
    end else begin
      if (feed_if.valid && feed_if.ready) begin
        codec_step(feed_q.pop_front());
        items_fed++;
      end
      if (feed_if.valid && !feed_if.ready) begin
        // hold the beat until taken
      end else if (feed_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        feed_if.valid   <= 1'b1;
        feed_if.in_byte <= feed_q[0].data;
        feed_if.in_last <= feed_q[0].last;
      end else begin
        feed_if.valid <= 1'b0;
      end
    end
  end

  // drain monitor
  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      drain_if.ready <= 1'b0;
    end else begin
      if (drain_if.valid && drain_if.ready) begin
        beats_checked++;
        if (drain_q.size() == 0) begin
          note_failure($sformatf("unexpected beat byte=%02h last=%0b",
                                 drain_if.out_byte, drain_if.out_last));
        end else begin
          want = drain_q.pop_front();
          if (drain_if.out_byte !== want.data || drain_if.out_last !== want.last) begin
            note_failure($sformatf("beat %0d expected byte=%02h last=%0b, got byte=%02h last=%0b",
                                   beats_checked, want.data, want.last,
                                   drain_if.out_byte, drain_if.out_last));
          end
        end
      end
      drain_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic push_beat(input logic [7:0] data, input logic last);
    feed_q.push_back('{data: data, last: last});
  endtask

  task automatic push_text(input string s, input logic last);
    for (int i = 0; i < s.len(); i++) begin
      push_beat(s[i], last && i == s.len() - 1);
    end
  endtask

  task automatic settle();
    while (feed_q.size() != 0 || drain_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.mode  <= m;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_mode = m;
    forget_group();
    mode_writes++;
  endtask

  task automatic queue_encode_burst(input int count);
    int len;
    int sent;
    sent = 0;
    while (sent < count) begin
      len = $urandom_range(10, 1);
      for (int i = 0; i < len; i++) begin
        push_beat(8'($urandom_range(255)), i == len - 1);
      end
      sent += len;
    end
    // leave a partial group behind for the next mode write to discard
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(2, 1)) push_beat(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic queue_decode_burst(input int count);
    logic [7:0] text[$];
    int sent;
    int groups;
    int pads;
    sent = 0;
    while (sent < count) begin
      text.delete();
      groups = $urandom_range(3, 1);
      for (int i = 0; i < 4 * groups; i++) begin
        if ($urandom_range(15) == 0) begin
          text.push_back(8'($urandom_range(255)));
        end else if ($urandom_range(31) == 0) begin
          text.push_back(PAD_CHAR);
        end else begin
          text.push_back(sextet_char(6'($urandom_range(63))));
        end
      end
      // final group padding: none, fourth only, both, third only
      pads = $urandom_range(3);
      if (pads == 1 || pads == 2) begin
        text[text.size() - 1] = PAD_CHAR;
      end
      if (pads >= 2) begin
        text[text.size() - 2] = PAD_CHAR;
      end
      // broken message with an incomplete final group
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(3, 1)) void'(text.pop_back());
      end
      for (int i = 0; i < text.size(); i++) begin
        push_beat(text[i], i == text.size() - 1);
      end
      sent += text.size();
    end
  endtask

  initial begin
    beat_t left;
    rst = 1'b1;
    feed_if.valid   = 1'b0;
    feed_if.in_byte = '0;
    feed_if.in_last = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.mode     = MODE_ENCODE;
    drain_if.ready  = 1'b0;
    cur_mode = MODE_ENCODE;
    forget_group();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // encode: full final group, one byte, two bytes
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h80, 1'b1);
    push_beat(8'hFF, 1'b1);
    push_beat(8'h01, 1'b0);
    push_beat(8'hFE, 1'b1);
    // partial group dropped by a mode write
    push_beat(8'h55, 1'b0);
    write_mode(MODE_ENCODE);
    push_beat(8'h7E, 1'b1);
    write_mode(MODE_DECODE);
    // decode: plain group, pad inside message, bad chars with third pad, both pads
    push_text("A/+z", 1'b0);
    push_text("09=a", 1'b0);
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_text("=A", 1'b1);
    push_text("QQ==", 1'b1);
    // incomplete final group
    push_text("AB", 1'b1);

    for (int p = 0; p < 4; p++) begin
      write_mode(MODE_ENCODE);
      idle_pct  = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      queue_encode_burst(36);
      write_mode(MODE_DECODE);
      idle_pct  = SEND_IDLE[p];
      stall_pct = RECV_STALL[p];
      queue_decode_burst(36);
    end

    while (feed_q.size() != 0) begin
      @(posedge clk);
    end
    for (int c = 0; c < 2000 && drain_q.size() != 0; c++) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);
    while (drain_q.size() != 0) begin
      left = drain_q.pop_front();
      note_failure($sformatf("missing beat byte=%02h last=%0b", left.data, left.last));
    end

    $display("fed %0d beats in encode and decode over four pressure settings, %0d mode writes",
             items_fed, mode_writes);
    $display("checked %0d output beats, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("run timed out");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/b64sc_pkg.sv
src/b64sc_in_if.sv
src/b64sc_out_if.sv
src/b64sc_cfg_if.sv
src/b64sc_front.sv
src/b64sc_queue.sv
src/b64sc_back.sv
src/base64_stream_codec_unit.sv
verif/base64_stream_codec_unit_test.sv
